// ===== design/wsd_pkg.sv =====
// ----------------------------------------------------------------------------
// wsd_pkg
// Types and codes shared by the WebSocket frame deframer modules.
// ----------------------------------------------------------------------------
package wsd_pkg;

    localparam int unsigned PHASE_W = 3;

    localparam logic [PHASE_W-1:0] PH_HEADER  = 3'd0;
    localparam logic [PHASE_W-1:0] PH_LENGTH  = 3'd1;
    localparam logic [PHASE_W-1:0] PH_EXT_HI  = 3'd2;
    localparam logic [PHASE_W-1:0] PH_EXT_LO  = 3'd3;
    localparam logic [PHASE_W-1:0] PH_MASK    = 3'd4;
    localparam logic [PHASE_W-1:0] PH_PAYLOAD = 3'd5;

    localparam logic [1:0] ST_DATA        = 2'd0;
    localparam logic [1:0] ST_EMPTY       = 2'd1;
    localparam logic [1:0] ST_UNSUPPORTED = 2'd2;
    localparam logic [1:0] ST_ABORT       = 2'd3;

    localparam logic       KIND_BYTE = 1'b0;
    localparam logic       KIND_LOST = 1'b1;

    localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
    localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

    localparam logic [15:0] LIMIT_RESET = 16'hFFFF;

    typedef struct packed {
        logic       kind;
        logic [7:0] rx_byte;
    } t_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  payload_byte;
        logic [6:0]  frame_opcode;
        logic [15:0] byte_count;
        logic        last;
    } t_result;

endpackage

// ===== design/wsd_in_if.sv =====
// ----------------------------------------------------------------------------
// wsd_in_if
// Receive channel: one received byte or a connection lost event per beat.
// ----------------------------------------------------------------------------
interface wsd_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] rx_byte;

    modport source (output valid, output kind, output rx_byte, input ready);
    modport sink   (input valid, input kind, input rx_byte, output ready);
endinterface

// ===== design/wsd_out_if.sv =====
// ----------------------------------------------------------------------------
// wsd_out_if
// Result channel: one payload byte or frame status per beat.
// ----------------------------------------------------------------------------
interface wsd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [7:0]  payload_byte;
    logic [6:0]  frame_opcode;
    logic [15:0] byte_count;
    logic        last;

    modport source (output valid, output status, output payload_byte,
                    output frame_opcode, output byte_count, output last,
                    input ready);
    modport sink   (input valid, input status, input payload_byte,
                    input frame_opcode, input byte_count, input last,
                    output ready);
endinterface

// ===== design/websocket_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// Parses received WebSocket frames (16-bit lengths) and delivers unmasked
// payload bytes with frame status.
// ----------------------------------------------------------------------------
//  Channel   Dir  Handshake      Payload
//  i_in      in   valid/ready    kind, rx_byte
//  o_out     out  valid/ready    status, payload_byte, frame_opcode,
//                                byte_count, last
//  i_cfg_*   in   write enable   buffer_limit (16 bit)
//
// One beat is accepted per cycle unless stalled, held in the input register,
// and any result goes to the output register. The throughput is set by the
// single parser step between input and result registers. Reset is
// synchronous and returns the parser to wait for a header. A stalled result
// stops the parser and then the input only when both registers are full.
// ----------------------------------------------------------------------------
module websocket_frame_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    wsd_in_if.sink      i_in,
    wsd_out_if.source   o_out
);

    wsd_pkg::t_item   in_item;
    wsd_pkg::t_item   stg_item;
    wsd_pkg::t_result res;
    wsd_pkg::t_result out_res;
    logic             stg_valid;
    logic             out_free;
    logic             advance;
    logic             res_valid;

    assign in_item.kind    = i_in.kind;
    assign in_item.rx_byte = i_in.rx_byte;
    assign advance         = stg_valid && out_free;

    wsd_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (i_in.ready),
        .i_item  (in_item),
        .i_take  (advance),
        .o_valid (stg_valid),
        .o_item  (stg_item)
    );

    wsd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_fire      (advance),
        .i_item      (stg_item),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    wsd_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (res_valid),
        .i_res   (res),
        .i_ready (o_out.ready),
        .o_valid (o_out.valid),
        .o_free  (out_free),
        .o_res   (out_res)
    );

    assign o_out.status       = out_res.status;
    assign o_out.payload_byte = out_res.payload_byte;
    assign o_out.frame_opcode = out_res.frame_opcode;
    assign o_out.byte_count   = out_res.byte_count;
    assign o_out.last         = out_res.last;

endmodule

// ===== design/wsd_in_stage.sv =====
// ----------------------------------------------------------------------------
// wsd_in_stage
// Input register: captures one beat and holds it until the parser takes it.
// ----------------------------------------------------------------------------
module wsd_in_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  wsd_pkg::t_item i_item,
    input  logic          i_take,
    output logic          o_valid,
    output wsd_pkg::t_item o_item
);

    logic           r_valid;
    wsd_pkg::t_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

// ===== design/wsd_parser.sv =====
// ----------------------------------------------------------------------------
// wsd_parser
// Frame header state machine, mask key store and payload unmasking.
// ----------------------------------------------------------------------------
module wsd_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [15:0]      i_cfg_data,
    input  logic             i_fire,
    input  wsd_pkg::t_item   i_item,
    output logic             o_res_valid,
    output wsd_pkg::t_result o_res
);

    logic [15:0]               r_limit;
    logic [wsd_pkg::PHASE_W-1:0] r_phase, n_phase;
    logic [6:0]                r_opcode, n_opcode;
    logic                      r_masked, n_masked;
    logic [15:0]               r_len, n_len;
    logic [31:0]               r_key, n_key;
    logic [1:0]                r_mask_seen, n_mask_seen;
    logic [15:0]               r_seen, n_seen;
    logic [15:0]               r_delivered, n_delivered;

    logic        after_len;
    logic [15:0] len_new;
    logic        masked_new;
    logic [7:0]  b;
    logic [7:0]  key_byte;
    logic [15:0] want;
    logic [15:0] dlv_inc;
    logic [15:0] seen_inc;

    assign b        = i_item.rx_byte;
    assign key_byte = r_masked ? r_key[{r_seen[1:0], 3'b000} +: 8] : 8'h00;
    assign want     = (r_len < r_limit) ? r_len : r_limit;
    assign dlv_inc  = r_delivered + 16'd1;
    assign seen_inc = r_seen + 16'd1;

    always_comb begin
        n_phase     = r_phase;
        n_opcode    = r_opcode;
        n_masked    = r_masked;
        n_len       = r_len;
        n_key       = r_key;
        n_mask_seen = r_mask_seen;
        n_seen      = r_seen;
        n_delivered = r_delivered;
        after_len   = 1'b0;
        len_new     = r_len;
        masked_new  = r_masked;
        o_res_valid = 1'b0;
        o_res       = '0;
        o_res.frame_opcode = r_opcode;

        if (i_fire) begin
            if (i_item.kind == wsd_pkg::KIND_LOST) begin
                if (r_phase != wsd_pkg::PH_HEADER) begin
                    n_phase          = wsd_pkg::PH_HEADER;
                    o_res_valid      = 1'b1;
                    o_res.status     = wsd_pkg::ST_ABORT;
                    o_res.byte_count = r_delivered;
                    o_res.last       = 1'b1;
                end
            end else begin
                unique case (r_phase)
                    wsd_pkg::PH_HEADER: begin
                        n_opcode = b[6:0];
                        n_phase  = wsd_pkg::PH_LENGTH;
                    end
                    wsd_pkg::PH_LENGTH: begin
                        n_masked   = b[7];
                        masked_new = b[7];
                        if (b[6:0] == wsd_pkg::LEN_CODE_EXT16) begin
                            n_phase = wsd_pkg::PH_EXT_HI;
                        end else if (b[6:0] == wsd_pkg::LEN_CODE_EXT64) begin
                            n_phase      = wsd_pkg::PH_HEADER;
                            o_res_valid  = 1'b1;
                            o_res.status = wsd_pkg::ST_UNSUPPORTED;
                            o_res.last   = 1'b1;
                        end else begin
                            len_new   = {9'd0, b[6:0]};
                            after_len = 1'b1;
                        end
                    end
                    wsd_pkg::PH_EXT_HI: begin
                        n_len   = {b, 8'h00};
                        n_phase = wsd_pkg::PH_EXT_LO;
                    end
                    wsd_pkg::PH_EXT_LO: begin
                        len_new   = {r_len[15:8], b};
                        after_len = 1'b1;
                    end
                    wsd_pkg::PH_MASK: begin
                        for (int i = 0; i < 4; i++) begin
                            if (r_mask_seen == 2'(i)) begin
                                n_key[8*i +: 8] = b;
                            end
                        end
                        n_mask_seen = r_mask_seen + 2'd1;
                        if (r_mask_seen == 2'd3) begin
                            n_phase = wsd_pkg::PH_PAYLOAD;
                        end
                    end
                    wsd_pkg::PH_PAYLOAD: begin
                        n_seen = seen_inc;
                        // Bytes past the limit are consumed with no result.
                        if (r_delivered < r_limit) begin
                            n_delivered        = dlv_inc;
                            o_res_valid        = 1'b1;
                            o_res.status       = wsd_pkg::ST_DATA;
                            o_res.payload_byte = b ^ key_byte;
                            o_res.byte_count   = dlv_inc;
                            o_res.last         = (dlv_inc == want);
                        end
                        if (seen_inc == r_len) begin
                            n_phase = wsd_pkg::PH_HEADER;
                        end
                    end
                    default: begin
                        n_phase = wsd_pkg::PH_HEADER;
                    end
                endcase

                if (after_len) begin
                    n_len = len_new;
                    if (len_new == 16'd0) begin
                        // An empty frame never reads its mask key.
                        n_phase      = wsd_pkg::PH_HEADER;
                        o_res_valid  = 1'b1;
                        o_res.status = wsd_pkg::ST_EMPTY;
                        o_res.last   = 1'b1;
                    end else begin
                        n_seen      = 16'd0;
                        n_delivered = 16'd0;
                        n_mask_seen = 2'd0;
                        n_phase     = masked_new ? wsd_pkg::PH_MASK : wsd_pkg::PH_PAYLOAD;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit     <= wsd_pkg::LIMIT_RESET;
            r_phase     <= wsd_pkg::PH_HEADER;
            r_opcode    <= '0;
            r_masked    <= 1'b0;
            r_len       <= '0;
            r_key       <= '0;
            r_mask_seen <= '0;
            r_seen      <= '0;
            r_delivered <= '0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
            r_phase     <= n_phase;
            r_opcode    <= n_opcode;
            r_masked    <= n_masked;
            r_len       <= n_len;
            r_key       <= n_key;
            r_mask_seen <= n_mask_seen;
            r_seen      <= n_seen;
            r_delivered <= n_delivered;
        end
    end

    a_idle_lost_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_item.kind == wsd_pkg::KIND_LOST && r_phase == wsd_pkg::PH_HEADER
        |-> !o_res_valid)
        else $error("connection lost while idle produced a result");

    a_data_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.status == wsd_pkg::ST_DATA |-> o_res.byte_count != 16'd0)
        else $error("payload byte with zero count");

    a_length_leaves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && r_phase == wsd_pkg::PH_LENGTH |=> r_phase != wsd_pkg::PH_LENGTH)
        else $error("length phase did not advance");

endmodule

// ===== design/wsd_out_stage.sv =====
// ----------------------------------------------------------------------------
// wsd_out_stage
// Result register: holds one result beat until the sink takes it.
// ----------------------------------------------------------------------------
module wsd_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  wsd_pkg::t_result i_res,
    input  logic             i_ready,
    output logic             o_valid,
    output logic             o_free,
    output wsd_pkg::t_result o_res
);

    logic             r_valid;
    wsd_pkg::t_result r_res;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    a_load_only_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_free)
        else $error("result loaded over an untaken beat");

endmodule
